/* sv/cents_literal_parser_unit_macros.svh */
// assertion macros for the cents literal parser
`ifndef CENTS_LITERAL_PARSER_UNIT_MACROS_SVH
`define CENTS_LITERAL_PARSER_UNIT_MACROS_SVH

// checked only out of reset
`define CLP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CLP_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/clp_pkg.sv */
`default_nettype none
package clp_pkg;

  localparam int AccW = 63;
  localparam int FracW = 7;

  typedef enum logic [1:0] {
    PH_WHOLE = 2'd0,
    PH_SEP   = 2'd1,
    PH_FRAC  = 2'd2,
    PH_MULT  = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [AccW-1:0]   acc;
    logic [1:0]        fcnt;
    logic [FracW-1:0]  fcents;
    logic              failed;
    logic [AccW-1:0]   sum;
    logic              sum_ovf;
  } state_t;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            fail;
  } sfx_t;

  localparam logic [AccW-1:0] AMOUNT_MAX = {AccW{1'b1}};
  localparam logic [AccW-1:0] LIM_K = AMOUNT_MAX / 63'd1000;
  localparam logic [AccW-1:0] LIM_M = AMOUNT_MAX / 63'd1000000;
  localparam logic [AccW-1:0] LIM_B = AMOUNT_MAX / 63'd1000000000;

  localparam logic [9:0]  MUL_K = 10'd1000;
  localparam logic [19:0] MUL_M = 20'd1000000;
  localparam logic [29:0] MUL_B = 30'd1000000000;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_K_UP  = 8'h4B;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_M_UP  = 8'h4D;
  localparam logic [7:0] CH_M_LO  = 8'h6D;
  localparam logic [7:0] CH_B_UP  = 8'h42;
  localparam logic [7:0] CH_B_LO  = 8'h62;

  localparam state_t STATE_RST = '{
    phase:   PH_WHOLE,
    acc:     '0,
    fcnt:    '0,
    fcents:  '0,
    failed:  1'b0,
    sum:     '0,
    sum_ovf: 1'b0
  };

endpackage
`default_nettype wire

/* sv/cents_literal_parser_unit.sv */
// cents literal parser
// input channel: one character beat per cycle on in_character, in_last
// marks the final character of a literal; a beat is taken when in_valid
// is high and in_stall is low
// output channel: one beat per literal on out_value_cents and out_status,
// the amount times one hundred, or zero with status 1 on a malformed
// literal or an amount above the signed 64-bit maximum
// throughput: one character per cycle, set by the single parse step that
// sits between the input register and the state and result registers
// the result of a last beat is registered in the result register when
// the beat leaves the input register and shows on out_valid from then on
// only a last beat waits on a stalled output register; other beats keep
// flowing and update the parse state, so in_stall rises only while a
// last beat is held behind a stalled result
// a stalled result holds its value until taken
// reset clears the parse state, the input valid and the result valid
`default_nettype none
module cents_literal_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_character,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [62:0]      out_value_cents,
  output logic             out_status
);
  import clp_pkg::*;

  logic        q_valid_r;
  logic        q_valid_nxt;
  logic [7:0]  q_char_r;
  logic        q_last_r;
  state_t      state_r;
  state_t      state_nxt;
  state_t      step_nxt;
  logic [62:0] res_value;
  logic        res_status;
  logic        out_free;
  logic        advance;

  assign advance     = q_valid_r && (!q_last_r || out_free);
  assign in_stall    = q_valid_r && !advance;
  assign q_valid_nxt = in_stall ? q_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else q_valid_r <= q_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_char_r <= in_character;
      q_last_r <= in_last;
    end
  end

  clp_step u_step (
    .cur        (state_r),
    .ch         (q_char_r),
    .nxt        (step_nxt),
    .res_value  (res_value),
    .res_status (res_status)
  );

  always_comb begin
    state_nxt = state_r;
    if (advance) state_nxt = q_last_r ? STATE_RST : step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= STATE_RST;
    else state_r <= state_nxt;
  end

  clp_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance && q_last_r),
    .load_value      (res_value),
    .load_status     (res_status),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_cents (out_value_cents),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

/* sv/clp_suffix.sv */
`default_nettype none
module clp_suffix (
  input  wire logic [62:0] base,
  input  wire logic [7:0]  ch,
  output clp_pkg::sfx_t    res
);
  import clp_pkg::*;

  logic [63:0] prod_k;
  logic [63:0] prod_m;
  logic [63:0] prod_b;

  // operand is below the limit whenever the product is used
  assign prod_k = 64'(base[53:0]) * 64'(MUL_K);
  assign prod_m = 64'(base[43:0]) * 64'(MUL_M);
  assign prod_b = 64'(base[33:0]) * 64'(MUL_B);

  always_comb begin
    res.acc  = base;
    res.fail = 1'b0;
    case (ch)
      CH_SPACE, CH_TAB: begin
        res.acc = base;
      end
      CH_K_UP, CH_K_LO: begin
        res.fail = base > LIM_K;
        res.acc  = prod_k[62:0];
      end
      CH_M_UP, CH_M_LO: begin
        res.fail = base > LIM_M;
        res.acc  = prod_m[62:0];
      end
      CH_B_UP, CH_B_LO: begin
        res.fail = base > LIM_B;
        res.acc  = prod_b[62:0];
      end
      default: begin
        res.fail = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/clp_step.sv */
`default_nettype none
module clp_step (
  input  wire clp_pkg::state_t cur,
  input  wire logic [7:0]      ch,
  output clp_pkg::state_t      nxt,
  output logic [62:0]          res_value,
  output logic                 res_status
);
  import clp_pkg::*;

  logic        digit;
  logic [3:0]  d;
  logic [66:0] whole_wide;
  logic [6:0]  frac2;
  logic [6:0]  frac_add;
  logic [63:0] sum_w;
  logic [62:0] sfx_base;
  sfx_t        sfx;

  assign digit = ch inside {[CH_0:CH_9]};
  assign d     = digit ? 4'(ch - CH_0) : 4'd0;

  assign whole_wide = 67'(cur.acc) * 67'd10 + 67'(d) * 67'd100;

  assign frac2    = 7'(11'(cur.fcents) * 11'd10 + 11'(d));
  assign frac_add = (cur.phase == PH_SEP) ? 7'(7'(d) * 7'd10) : frac2;
  assign sum_w    = 64'(cur.acc) + 64'(frac_add);

  // pending fraction is already folded into sum
  assign sfx_base = (cur.phase == PH_FRAC) ? cur.sum : cur.acc;

  clp_suffix u_suffix (
    .base (sfx_base),
    .ch   (ch),
    .res  (sfx)
  );

  always_comb begin
    nxt = cur;
    if (!cur.failed) begin
      case (cur.phase)
        PH_WHOLE: begin
          if (digit) begin
            if (whole_wide[66:63] != 4'd0) nxt.failed = 1'b1;
            else nxt.acc = whole_wide[62:0];
          end else if (ch == CH_DOT || ch == CH_COMMA) begin
            nxt.phase = PH_SEP;
          end else begin
            nxt.phase  = PH_MULT;
            nxt.acc    = sfx.acc;
            nxt.failed = sfx.fail;
          end
        end
        PH_SEP: begin
          if (!digit) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.phase   = PH_FRAC;
            nxt.fcents  = 7'(d);
            nxt.fcnt    = 2'd1;
            nxt.sum     = sum_w[62:0];
            nxt.sum_ovf = sum_w[63];
          end
        end
        PH_FRAC: begin
          if (digit) begin
            if (cur.fcnt == 2'd1) begin
              nxt.fcents  = frac2;
              nxt.fcnt    = 2'd2;
              nxt.sum     = sum_w[62:0];
              nxt.sum_ovf = sum_w[63];
            end
          end else begin
            nxt.phase = PH_MULT;
            if (cur.sum_ovf) begin
              nxt.failed = 1'b1;
            end else begin
              nxt.acc    = sfx.acc;
              nxt.failed = sfx.fail;
            end
          end
        end
        PH_MULT: begin
          nxt.acc    = sfx.acc;
          nxt.failed = sfx.fail;
        end
        default: begin
          nxt.failed = 1'b1;
        end
      endcase
    end
  end

  // end of literal: empty fraction fails, open fraction closes
  always_comb begin
    res_status = nxt.failed || (nxt.phase == PH_SEP) ||
                 (nxt.phase == PH_FRAC && nxt.sum_ovf);
    if (res_status) res_value = '0;
    else if (nxt.phase == PH_FRAC) res_value = nxt.sum;
    else res_value = nxt.acc;
  end

endmodule
`default_nettype wire

/* sv/clp_out_stage.sv */
`default_nettype none
module clp_out_stage (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire logic [62:0] load_value,
  input  wire logic        load_status,
  output logic             free,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [62:0]      out_value_cents,
  output logic             out_status
);
  logic        valid_r;
  logic        valid_nxt;
  logic [62:0] value_r;
  logic        status_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= load_value;
      status_r <= load_status;
    end
  end

  assign out_valid       = valid_r;
  assign out_value_cents = value_r;
  assign out_status      = status_r;

endmodule
`default_nettype wire

/* sv/clp_checker.sv */
`default_nettype none
`include "cents_literal_parser_unit_macros.svh"
module clp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [62:0] out_value_cents,
  input wire logic        out_status
);
  logic        err_beat;
  logic        held;
  logic [63:0] out_beat;

  assign err_beat = out_valid && out_status;
  assign held     = out_valid && out_stall;
  assign out_beat = {out_value_cents, out_status};

  // an error beat carries no amount
  `CLP_ASSERT_RST(a_err_zero, clk, rst_n, err_beat |-> out_value_cents == '0, "error beat with amount")
  // input backs up only behind a stalled result
  `CLP_ASSERT_RST(a_stall_src, clk, rst_n, !out_stall |-> !in_stall, "input stall with output free")
  // stalled result beat holds
  `CLP_ASSERT_RST(a_out_hold, clk, rst_n, held |=> out_valid && $stable(out_beat), "stalled beat changed")
  // no result right out of reset
  `CLP_ASSERT(a_rst_idle, clk, !rst_n |=> !out_valid && !in_stall, "busy after reset")
endmodule

bind cents_literal_parser_unit clp_checker u_clp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_value_cents (out_value_cents),
  .out_status      (out_status)
);
`default_nettype wire
